### design/hm74_pkg.sv
package hm74_pkg;

    localparam int NIBBLE_BITS = 4;
    localparam int CODE_BITS   = 7;
    localparam int RES_MAX     = 8;
    localparam int CNT_W       = $clog2(RES_MAX + 1);

    localparam logic MODE_ENCODE = 1'b0;
    localparam logic MODE_DECODE = 1'b1;

    // Per-frame state of the codec.
    typedef struct packed {
        logic [CODE_BITS-1:0]   bits;
        logic [2:0]             fill;
        logic [NIBBLE_BITS-1:0] held;
        logic                   held_valid;
    } t_state;

    // One result item as it leaves the block.
    typedef struct packed {
        logic [2:0] value;
        logic       trailer;
        logic       err;
        logic       last;
    } t_result;

    // Data nibble (d0 in bit 0) to code word, code bit i in bit i.
    function automatic logic [CODE_BITS-1:0] encode_nibble(input logic [NIBBLE_BITS-1:0] d);
        logic p1;
        logic p2;
        logic p3;
        p1 = d[0] ^ d[1] ^ d[3];
        p2 = d[0] ^ d[2] ^ d[3];
        p3 = d[1] ^ d[2] ^ d[3];
        return {d[3], d[2], d[1], p3, d[0], p2, p1};
    endfunction

    // Correct a single-bit error and pull out the data nibble.
    function automatic logic [NIBBLE_BITS-1:0] decode_word(input logic [CODE_BITS-1:0] c);
        logic [2:0]           pos;
        logic [CODE_BITS-1:0] fixed;
        pos[0] = c[0] ^ c[2] ^ c[4] ^ c[6];
        pos[1] = c[1] ^ c[2] ^ c[5] ^ c[6];
        pos[2] = c[3] ^ c[4] ^ c[5] ^ c[6];
        fixed  = c;
        if (pos != 3'd0) begin
            fixed = c ^ (7'd1 << (pos - 3'd1));
        end
        return {fixed[6], fixed[5], fixed[4], fixed[2]};
    endfunction

endpackage

### design/hamming74_framed_stream_codec_core.sv
// Flow: an input transfer lands in the input register; when the result buffer can take its
// results, it is coded and they are loaded into the buffer, whose entry 0 drives the output.
// Throughput: one input transfer per cycle while the result buffer keeps up; results leave one
// per cycle while the receiver is ready; 4 data bits give 7 results, a codeword gives 4.
// Reset: synchronous, active low; it selects encode mode and clears frame state and buffers.
module hamming74_framed_stream_codec_core (
    input  logic       i_clk,
    input  logic       i_rst_n,
    // Configuration: bit 0 is codec_mode (0 encode, 1 decode).
    input  logic       i_cfg_wr_en,
    input  logic       i_cfg_wr_data,
    // Input stream.
    input  logic       i_s_axis_tvalid,
    output logic       o_s_axis_tready,
    input  logic [7:0] i_s_axis_tdata,   // [7:0] in_value
    input  logic       i_s_axis_tlast,   // in_last
    // Result stream.
    output logic       o_m_axis_tvalid,
    input  logic       i_m_axis_tready,
    output logic [7:0] o_m_axis_tdata,   // [2:0] out_value, [7:3] zero
    output logic [1:0] o_m_axis_tuser,   // [0] is_trailer, [1] frame_error
    output logic       o_m_axis_tlast    // out_last
);

    // Mode and per-frame codec state.
    logic                       r_mode;
    hm74_pkg::t_state           r_state;
    hm74_pkg::t_state           n_state;

    // Input register: holds one accepted item until the result buffer can take its results.
    logic                       r_in_valid;
    logic [7:0]                 r_in_value;
    logic                       r_in_last;

    // Result buffer: a short shift line, entry 0 is always the one on the output.
    hm74_pkg::t_result          r_res [hm74_pkg::RES_MAX];
    hm74_pkg::t_result          n_res [hm74_pkg::RES_MAX];
    logic [hm74_pkg::CNT_W-1:0] r_cnt;
    logic [hm74_pkg::CNT_W-1:0] n_cnt;

    logic                       w_take;
    logic                       w_step_go;
    logic                       w_load;
    logic                       w_in_take;

    assign w_take    = o_m_axis_tvalid && i_m_axis_tready;
    // An item that causes no result only updates the codec state, so it is coded at once.
    // One that causes results waits until the buffer is empty or its last result leaves.
    assign w_step_go = r_in_valid &&
                       ((n_cnt == '0) || (r_cnt == '0) ||
                        ((r_cnt == hm74_pkg::CNT_W'(1)) && w_take));
    assign w_load    = w_step_go && (n_cnt != '0);
    assign o_s_axis_tready = !r_in_valid || w_step_go;
    assign w_in_take       = i_s_axis_tvalid && o_s_axis_tready;

    hm74_step u_step (
        .i_mode  (r_mode),
        .i_state (r_state),
        .i_value (r_in_value),
        .i_last  (r_in_last),
        .o_next  (n_state),
        .o_res   (n_res),
        .o_cnt   (n_cnt)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode     <= hm74_pkg::MODE_ENCODE;
            r_state    <= '0;
            r_in_valid <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                // A mode change abandons whatever frame was in progress.
                r_mode  <= i_cfg_wr_data;
                r_state <= '0;
            end else if (w_step_go) begin
                r_state <= n_state;
            end
            if (w_in_take) begin
                r_in_valid <= 1'b1;
            end else if (w_step_go) begin
                r_in_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_take) begin
            r_in_value <= i_s_axis_tdata;
            r_in_last  <= i_s_axis_tlast;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (w_load) begin
            r_cnt <= n_cnt;
        end else if (w_take) begin
            r_cnt <= r_cnt - hm74_pkg::CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_res <= n_res;
        end else if (w_take) begin
            for (int k = 0; k < hm74_pkg::RES_MAX - 1; k++) begin
                r_res[k] <= r_res[k + 1];
            end
        end
    end

    assign o_m_axis_tvalid = (r_cnt != '0);
    assign o_m_axis_tdata  = {5'b00000, r_res[0].value};
    assign o_m_axis_tuser  = {r_res[0].err, r_res[0].trailer};
    assign o_m_axis_tlast  = r_res[0].last;

    // The buffer never holds more results than one item can cause.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= hm74_pkg::CNT_W'(hm74_pkg::RES_MAX))
        else $error("result buffer count out of range");

    // The final result of a frame is always the last one of its burst.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && o_m_axis_tlast) |-> (r_cnt == hm74_pkg::CNT_W'(1)))
        else $error("frame end result is not the last buffered result");

    // A frame error is only ever flagged on the final result of a frame.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && o_m_axis_tuser[1]) |-> o_m_axis_tlast)
        else $error("frame error flagged before the end of the frame");

    // A mode write leaves no partial group and no held group behind.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_wr_en |=> ((r_state.fill == 3'd0) && !r_state.held_valid))
        else $error("frame state not cleared by mode write");

endmodule

### design/hm74_step.sv
module hm74_step (
    input  logic                        i_mode,
    input  hm74_pkg::t_state            i_state,
    input  logic [7:0]                  i_value,
    input  logic                        i_last,
    output hm74_pkg::t_state            o_next,
    output hm74_pkg::t_result           o_res [hm74_pkg::RES_MAX],
    output logic [hm74_pkg::CNT_W-1:0]  o_cnt
);

    always_comb begin
        logic [2:0] fill;
        logic [2:0] fill1;
        logic [6:0] gb;
        logic [6:0] code;
        logic [3:0] nib;
        logic [2:0] pad;
        logic [2:0] n;
        logic       err;

        o_next = i_state;
        o_cnt  = '0;
        for (int k = 0; k < hm74_pkg::RES_MAX; k++) begin
            o_res[k] = '0;
        end
        fill  = '0;
        fill1 = '0;
        gb    = '0;
        code  = '0;
        nib   = '0;
        pad   = '0;
        n     = '0;
        err   = 1'b0;

        if (i_mode == hm74_pkg::MODE_ENCODE) begin
            fill  = {1'b0, i_state.fill[1:0]};
            gb    = {3'b000, i_state.bits[3:0] | ({3'b000, i_value[0]} << fill[1:0])};
            fill1 = fill + 3'd1;
            code  = hm74_pkg::encode_nibble(gb[3:0]);
            if (i_last || fill1 == 3'(hm74_pkg::NIBBLE_BITS)) begin
                for (int k = 0; k < hm74_pkg::CODE_BITS; k++) begin
                    o_res[k].value = {2'b00, code[k]};
                end
                o_next = '0;
                o_cnt  = hm74_pkg::CNT_W'(hm74_pkg::CODE_BITS);
                if (i_last) begin
                    // The trailer carries the number of zero bits padded in.
                    pad = 3'(3'(hm74_pkg::NIBBLE_BITS) - fill1);
                    o_res[hm74_pkg::CODE_BITS].value   = {pad[1:0], 1'b1};
                    o_res[hm74_pkg::CODE_BITS].trailer = 1'b1;
                    o_res[hm74_pkg::CODE_BITS].last    = 1'b1;
                    o_cnt = hm74_pkg::CNT_W'(hm74_pkg::CODE_BITS + 1);
                end
            end else begin
                o_next.bits = gb;
                o_next.fill = fill1;
            end
        end else if (!i_last) begin
            fill  = (i_state.fill >= 3'(hm74_pkg::CODE_BITS)) ? 3'd0 : i_state.fill;
            gb    = i_state.bits | (7'(i_value[0]) << fill);
            fill1 = fill + 3'd1;
            if (fill1 == 3'(hm74_pkg::CODE_BITS)) begin
                nib = hm74_pkg::decode_word(gb);
                // The previous group is known not to be the final one now.
                if (i_state.held_valid) begin
                    for (int k = 0; k < hm74_pkg::NIBBLE_BITS; k++) begin
                        o_res[k].value = {2'b00, i_state.held[k]};
                    end
                    o_cnt = hm74_pkg::CNT_W'(hm74_pkg::NIBBLE_BITS);
                end
                o_next.held       = nib;
                o_next.held_valid = 1'b1;
                o_next.bits       = '0;
                o_next.fill       = '0;
            end else begin
                o_next.bits = gb;
                o_next.fill = fill1;
            end
        end else begin
            pad = (i_value[3:1] > 3'(hm74_pkg::NIBBLE_BITS)) ? 3'(hm74_pkg::NIBBLE_BITS)
                                                             : i_value[3:1];
            err = (i_state.fill != 3'd0);
            n   = i_state.held_valid ? 3'(3'(hm74_pkg::NIBBLE_BITS) - pad) : 3'd0;
            if (n == 3'd0) begin
                // Lone end marker: even value, so it never looks like a trailer value.
                o_res[0].trailer = 1'b1;
                o_res[0].err     = err;
                o_res[0].last    = 1'b1;
                o_cnt            = hm74_pkg::CNT_W'(1);
            end else begin
                for (int k = 0; k < hm74_pkg::NIBBLE_BITS; k++) begin
                    if (3'(k) < n) begin
                        o_res[k].value = {2'b00, i_state.held[k]};
                        o_res[k].err   = (3'(k + 1) == n) ? err : 1'b0;
                        o_res[k].last  = (3'(k + 1) == n);
                    end
                end
                o_cnt = hm74_pkg::CNT_W'(n);
            end
            o_next = '0;
        end
    end

endmodule

### test/tb.sv
`timescale 1ns / 100ps

module tb;
    // Self-checking bench for the framed Hamming(7,4) stream codec. Every accepted input
    // transfer is run through a bit-level copy of the codec kept in this module, and each
    // result transfer is compared against the oldest expected result in arrival order.

    // A run with no transfer on either side for this many cycles counts as a hang.
    localparam int HANG_LIMIT = 1000;
    // Length of the deliberate receiver hold-off used to fill the block.
    localparam int HOLD_CYCLES = 150;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       cfg_we = 1'b0;
    logic       cfg_wd = 1'b0;
    logic       s_tvalid = 1'b0;
    logic [7:0] s_tdata = 8'h00;
    logic       s_tlast = 1'b0;
    logic       m_tready = 1'b0;
    wire        s_tready;
    wire        m_tvalid;
    wire  [7:0] m_tdata;
    wire  [1:0] m_tuser;
    wire        m_tlast;

    hamming74_framed_stream_codec_core dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_cfg_wr_en     (cfg_we),
        .i_cfg_wr_data   (cfg_wd),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),   // [7:0] in_value
        .i_s_axis_tlast  (s_tlast),   // in_last
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata),   // [2:0] out_value, [7:3] zero
        .o_m_axis_tuser  (m_tuser),   // [0] is_trailer, [1] frame_error
        .o_m_axis_tlast  (m_tlast)    // out_last
    );

    always #4 clk = ~clk;

    // Bench-side copy of the codec state and of its mode register.
    logic       cm_mode;
    logic [6:0] cm_bits;
    logic [2:0] cm_fill;
    logic [3:0] cm_held;
    logic       cm_held_v;

    // Results that the codec copy says are still due, oldest first.
    hm74_pkg::t_result pending_results[$];

    int n_sent   = 0;
    int n_recv   = 0;
    int n_errors = 0;

    // Random idling of each side can be switched off for a stretch of the run.
    logic src_idle_on  = 1'b1;
    logic sink_idle_on = 1'b1;

    // A test asks for a receiver hold-off by bumping hold_reqs; the receiver
    // notices the change on its clock edge and then counts the stretch itself.
    int hold_reqs = 0;
    int hold_seen = 0;
    int hold_left = 0;
    int idle_cycles = 0;

    // ------------------------------------------------------------------
    // Hamming helpers. The syndrome is the XOR of the 1-based positions of
    // all set bits, so a clean word has syndrome zero and a single flipped
    // bit gives its own position.
    // ------------------------------------------------------------------
    function automatic logic [2:0] ham_syndrome(input logic [6:0] w);
        logic [2:0] s;
        s = 3'd0;
        for (int i = 0; i < hm74_pkg::CODE_BITS; i++) begin
            if (w[i]) begin
                s = s ^ 3'(i + 1);
            end
        end
        return s;
    endfunction

    // Data sits at positions 3, 5, 6 and 7; the parity bits at positions 1, 2
    // and 4 are chosen so that the syndrome of the finished word is zero.
    function automatic logic [6:0] ham_encode(input logic [3:0] d);
        logic [6:0] w;
        logic [2:0] s;
        w    = 7'd0;
        w[2] = d[0];
        w[4] = d[1];
        w[5] = d[2];
        w[6] = d[3];
        s    = ham_syndrome(w);
        w[0] = s[0];
        w[1] = s[1];
        w[3] = s[2];
        return w;
    endfunction

    function automatic logic [3:0] ham_decode(input logic [6:0] w);
        logic [2:0] s;
        logic [6:0] f;
        s = ham_syndrome(w);
        f = w;
        if (s != 3'd0) begin
            f[s - 3'd1] = ~f[s - 3'd1];
        end
        return {f[6], f[5], f[4], f[2]};
    endfunction

    function automatic void push_result(input logic [2:0] v, input logic tr,
                                        input logic er, input logic la);
        hm74_pkg::t_result r;
        r.value   = v;
        r.trailer = tr;
        r.err     = er;
        r.last    = la;
        pending_results.push_back(r);
    endfunction

    function automatic void push_code(input logic [6:0] w);
        for (int i = 0; i < hm74_pkg::CODE_BITS; i++) begin
            push_result({2'b00, w[i]}, 1'b0, 1'b0, 1'b0);
        end
    endfunction

    function automatic void clear_codec_frame();
        cm_bits   = 7'd0;
        cm_fill   = 3'd0;
        cm_held   = 4'd0;
        cm_held_v = 1'b0;
    endfunction

    // Works out the results of one accepted input transfer and queues them.
    function automatic void codec_predict(input logic [7:0] v, input logic l);
        logic       b;
        logic [2:0] f;
        logic [3:0] pad;
        logic       e;
        int         n;
        b = v[0];
        if (cm_mode == hm74_pkg::MODE_ENCODE) begin
            f       = {1'b0, cm_fill[1:0]};
            cm_bits = (cm_bits | (7'(b) << f)) & 7'h0F;
            f       = f + 3'd1;
            if (l) begin
                // The final group is padded with zeros; the trailer tells how many.
                pad = 4'(hm74_pkg::NIBBLE_BITS) - {1'b0, f};
                push_code(ham_encode(cm_bits[3:0]));
                push_result({pad[1:0], 1'b1}, 1'b1, 1'b0, 1'b1);
                clear_codec_frame();
            end else if (f == 3'(hm74_pkg::NIBBLE_BITS)) begin
                push_code(ham_encode(cm_bits[3:0]));
                cm_bits = 7'd0;
                cm_fill = 3'd0;
            end else begin
                cm_fill = f;
            end
        end else if (!l) begin
            f       = (cm_fill >= 3'(hm74_pkg::CODE_BITS)) ? 3'd0 : cm_fill;
            cm_bits = (cm_bits | (7'(b) << f)) & 7'h7F;
            f       = f + 3'd1;
            if (f == 3'(hm74_pkg::CODE_BITS)) begin
                // A finished codeword releases the group held before it.
                if (cm_held_v) begin
                    for (int i = 0; i < hm74_pkg::NIBBLE_BITS; i++) begin
                        push_result({2'b00, cm_held[i]}, 1'b0, 1'b0, 1'b0);
                    end
                end
                cm_held   = ham_decode(cm_bits);
                cm_held_v = 1'b1;
                cm_bits   = 7'd0;
                cm_fill   = 3'd0;
            end else begin
                cm_fill = f;
            end
        end else begin
            // Trailer byte: bits 3..1 give the pad count, which saturates at four.
            pad = {1'b0, v[3:1]};
            e   = (cm_fill != 3'd0);
            if (pad > 4'(hm74_pkg::NIBBLE_BITS)) begin
                pad = 4'(hm74_pkg::NIBBLE_BITS);
            end
            n = cm_held_v ? (hm74_pkg::NIBBLE_BITS - int'(pad)) : 0;
            if (n == 0) begin
                // Nothing is left to emit, so only the end marker goes out.
                push_result(3'd0, 1'b1, e, 1'b1);
            end else begin
                for (int i = 0; i < n; i++) begin
                    push_result({2'b00, cm_held[i]}, 1'b0,
                                (i == n - 1) ? e : 1'b0, (i == n - 1) ? 1'b1 : 1'b0);
                end
            end
            clear_codec_frame();
        end
    endfunction

    // ------------------------------------------------------------------
    // Receiver: random stalls, plus the long hold-off on request.
    // ------------------------------------------------------------------
    always @(posedge clk) begin
        if (hold_seen != hold_reqs) begin
            hold_seen <= hold_reqs;
            hold_left <= HOLD_CYCLES;
            m_tready  <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            m_tready  <= 1'b0;
        end else if (sink_idle_on && $urandom_range(99) < 24) begin
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    // Result checker: every result transfer is matched with the oldest expectation.
    always @(posedge clk) begin
        hm74_pkg::t_result exp_r;
        if (rst_n && m_tvalid && m_tready) begin
            n_recv <= n_recv + 1;
            if (pending_results.size() == 0) begin
                $display("%0t: result transfer with nothing expected: data %h user %b last %b",
                         $time, m_tdata, m_tuser, m_tlast);
                n_errors++;
            end else begin
                exp_r = pending_results.pop_front();
                if (m_tdata !== {5'b00000, exp_r.value}) begin
                    $display("%0t: out_value expected %h actual %h", $time,
                             {5'b00000, exp_r.value}, m_tdata);
                    n_errors++;
                end
                if (m_tuser[0] !== exp_r.trailer) begin
                    $display("%0t: is_trailer expected %b actual %b", $time,
                             exp_r.trailer, m_tuser[0]);
                    n_errors++;
                end
                if (m_tuser[1] !== exp_r.err) begin
                    $display("%0t: frame_error expected %b actual %b", $time,
                             exp_r.err, m_tuser[1]);
                    n_errors++;
                end
                if (m_tlast !== exp_r.last) begin
                    $display("%0t: out_last expected %b actual %b", $time,
                             exp_r.last, m_tlast);
                    n_errors++;
                end
            end
        end
    end

    // Watchdog: ends the run when neither side has moved a transfer for too long.
    always @(posedge clk) begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= HANG_LIMIT) begin
            $display("%0t: no transfer for %0d cycles, %0d results still due",
                     $time, HANG_LIMIT, pending_results.size());
            $display("CHECK FAILED");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Sender side. The valid stays high from one item to the next unless an
    // idle cycle is taken, so it is never lowered and raised in one step.
    // ------------------------------------------------------------------
    task automatic send_item(input logic [7:0] v, input logic l);
        while (src_idle_on && $urandom_range(99) < 24) begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= v;
        s_tlast  <= l;
        do begin
            @(posedge clk);
        end while (!s_tready);
        codec_predict(v, l);
        n_sent++;
    endtask

    // Sends one code bit per transfer, with random junk in the ignored upper bits.
    task automatic send_codeword(input logic [3:0] nib, input logic [6:0] flips);
        logic [6:0] w;
        logic [7:0] r;
        w = ham_encode(nib) ^ flips;
        for (int i = 0; i < hm74_pkg::CODE_BITS; i++) begin
            r    = 8'($urandom);
            r[0] = w[i];
            send_item(r, 1'b0);
        end
    endtask

    // Waits until every due result is back, then lets the pipeline settle so
    // that items which cause no result have also left the block.
    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0) begin
            @(posedge clk);
        end
        repeat (8) @(posedge clk);
    endtask

    // Mode write while idle; any frame in progress is abandoned on both sides.
    task automatic set_mode(input logic m);
        drain_results();
        cfg_we <= 1'b1;
        cfg_wd <= m;
        @(posedge clk);
        cfg_we <= 1'b0;
        cm_mode = m;
        clear_codec_frame();
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Encoding: a full group with junk upper bits, then a one-bit tail padded
    // by three, and a frame made of a single last item.
    task automatic test_encode_frames();
        set_mode(hm74_pkg::MODE_ENCODE);
        send_item(8'hFF, 1'b0);
        send_item(8'hFE, 1'b0);
        send_item(8'h01, 1'b0);
        send_item(8'h80, 1'b0);
        send_item(8'hFF, 1'b1);
        send_item(8'h00, 1'b1);
    endtask

    // Decoding: a corrected error, a partial codeword ahead of the trailer,
    // a trailer with nothing held, and a pad count above four.
    task automatic test_decode_frames();
        set_mode(hm74_pkg::MODE_DECODE);
        send_codeword(4'hA, 7'b0001000);
        send_item(8'h01, 1'b0);
        send_item(8'hFE, 1'b0);
        send_item(8'h81, 1'b0);
        // Pad of two with the ignored low bit set; the frame error rides on the end.
        send_item(8'h05, 1'b1);
        send_item(8'hFF, 1'b1);
        send_codeword(4'h3, 7'b1000000);
        send_item(8'hFE, 1'b1);
    endtask

    // The receiver holds off for a long stretch while encode traffic keeps
    // coming, so the result buffer fills and the input side has to stall.
    task automatic test_backpressure();
        src_idle_on  <= 1'b0;
        sink_idle_on <= 1'b0;
        set_mode(hm74_pkg::MODE_ENCODE);
        hold_reqs <= hold_reqs + 1;
        for (int i = 0; i < 40; i++) begin
            send_item(8'($urandom), (i == 19 || i == 39));
        end
        drain_results();
        src_idle_on  <= 1'b1;
        sink_idle_on <= 1'b1;
    endtask

    // One random frame in the current mode. Decode frames are mostly well
    // formed, with some broken by a partial codeword and some pure noise.
    task automatic random_frame();
        int         len;
        int         kind;
        logic [6:0] flips;
        logic [7:0] r;
        if (cm_mode == hm74_pkg::MODE_ENCODE) begin
            len = ($urandom_range(9) == 0) ? $urandom_range(13, 24) : $urandom_range(1, 8);
            for (int i = 0; i < len; i++) begin
                send_item(8'($urandom), (i == len - 1));
            end
        end else begin
            kind = $urandom_range(99);
            if (kind < 85) begin
                len = $urandom_range(0, 3);
                for (int i = 0; i < len; i++) begin
                    flips = 7'd0;
                    if ($urandom_range(99) < 50) begin
                        flips[$urandom_range(6)] = 1'b1;
                    end else if ($urandom_range(99) < 10) begin
                        flips = 7'($urandom);
                    end
                    send_codeword(4'($urandom), flips);
                end
                if (kind >= 70) begin
                    len = $urandom_range(1, 6);
                    for (int i = 0; i < len; i++) begin
                        send_item(8'($urandom), 1'b0);
                    end
                end
                r = 8'($urandom);
                if ($urandom_range(99) < 80) begin
                    r[3:1] = 3'($urandom_range(0, 4));
                end
                send_item(r, 1'b1);
            end else begin
                len = $urandom_range(1, 20);
                for (int i = 0; i < len; i++) begin
                    send_item(8'($urandom), (i == len - 1));
                end
            end
        end
    endtask

    // Random phases alternate the mode; one phase runs with no idling at all,
    // and some phases end inside a frame that the next mode write abandons.
    task automatic test_random_traffic();
        int start;
        int len;
        for (int ph = 0; ph < 6; ph++) begin
            src_idle_on  <= (ph != 2);
            sink_idle_on <= (ph != 2);
            set_mode((ph % 2 == 1) ? hm74_pkg::MODE_DECODE : hm74_pkg::MODE_ENCODE);
            start = n_sent;
            while (n_sent - start < 58) begin
                random_frame();
            end
            if ($urandom_range(1) == 1) begin
                len = $urandom_range(1, 9);
                for (int i = 0; i < len; i++) begin
                    send_item(8'($urandom), 1'b0);
                end
            end
        end
    endtask

    initial begin
        cm_mode = hm74_pkg::MODE_ENCODE;
        clear_codec_frame();
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_encode_frames();
        test_decode_frames();
        test_backpressure();
        test_random_traffic();

        drain_results();
        if (pending_results.size() != 0) begin
            $display("%0t: %0d expected results never arrived", $time,
                     pending_results.size());
            n_errors++;
        end
        $display("Ran %0d input and %0d result transfers over encode and decode phases,",
                 n_sent, n_recv);
        $display("with corrected errors, broken frames, padding trailers and a full stall.");
        if (n_errors == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
